// ===== hw/rtl/idxq_pkg.sv =====
package idxq_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_READ   = 2'd2,
        CMD_REMOVE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_FETCH = 2'd1,
        S_SHIFT = 2'd2,
        S_DONE  = 2'd3
    } t_state;

endpackage

// ===== hw/rtl/idxq_if.sv =====
interface idxq_req_if import idxq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               cmd;
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         position;

    modport source (output valid, output cmd, output value, output position, input ready);
    modport sink   (input valid, input cmd, input value, input position, output ready);
endinterface

interface idxq_rsp_if import idxq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] data_out;
    logic [1:0]               status;
    logic [CNT_W-1:0]         fill_count;

    modport source (output valid, output data_out, output status, output fill_count, input ready);
    modport sink   (input valid, input data_out, input status, input fill_count, output ready);
endinterface

// ===== hw/rtl/indexed_removal_queue_top.sv =====
// Ordered queue of signed 32-bit values with removal at any position.
// Requests arrive on i_req (cmd, value, position); every request yields one
// response on o_rsp (data_out, status, fill_count) with valid/ready transfers.
// Commands: push at tail, pop head, read at position, remove at position.
// A push on a full queue is dropped with status full; a pop on an empty queue
// or a position not below the fill count reports a miss and changes nothing.
// A push or a miss goes straight to the done state; a read passes through the
// fetch state for the registered memory read; a pop or remove fetches the entry
// and then shifts each later entry down into the gap (a pop uses position 0).
// A new request is accepted only after the done state has loaded the response,
// so no request overlaps the one before it.
// The gap is closed one entry per cycle through the single read port of the
// entry memory, with one shared index unit (adders and compare) driving the move.
// One request is processed at a time; i_req.ready is high only while idle.
// The response sits in an output register, so the next request is accepted
// while a finished response still waits; a response that cannot be loaded
// because the receiver stalls holds the sequencer until the register frees.
// Synchronous reset empties the queue and drops any pending response.
module indexed_removal_queue_top import idxq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    idxq_req_if.sink    i_req,
    idxq_rsp_if.source  o_rsp
);

    logic signed [DATA_W-1:0] mem [DEPTH];

    t_state                   r_state,      n_state;
    t_cmd                     r_cmd,        n_cmd;
    logic [IDX_W-1:0]         r_idx,        n_idx;
    logic [CNT_W-1:0]         r_count,      n_count;
    logic signed [DATA_W-1:0] r_res_data,   n_res_data;
    t_status                  r_res_status, n_res_status;
    logic                     r_out_valid,  n_out_valid;
    logic signed [DATA_W-1:0] r_out_data,   n_out_data;
    t_status                  r_out_status, n_out_status;
    logic [CNT_W-1:0]         r_out_count,  n_out_count;
    logic signed [DATA_W-1:0] r_rd_data;

    logic                     w_in_acc;
    t_cmd                     w_in_cmd;
    logic [IDX_W-1:0]         w_in_addr;
    logic                     w_in_miss;
    logic                     w_full;
    logic                     w_out_free;
    logic [CNT_W-1:0]         w_step;
    logic [CNT_W-1:0]         w_src;
    logic                     w_more;
    logic                     w_we;
    logic [IDX_W-1:0]         w_wr_addr;
    logic signed [DATA_W-1:0] w_wr_data;
    logic [IDX_W-1:0]         w_rd_addr;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_in_acc    = i_req.valid && i_req.ready;
    assign w_in_cmd    = t_cmd'(i_req.cmd);
    assign w_in_addr   = (w_in_cmd == CMD_POP) ? IDX_W'(0) : i_req.position;
    assign w_full      = (r_count == CNT_W'(DEPTH));
    assign w_in_miss   = (w_in_cmd == CMD_POP) ? (r_count == CNT_W'(0))
                                               : ({1'b0, i_req.position} >= r_count);
    assign w_out_free  = !r_out_valid || o_rsp.ready;

    // Shared index unit: during a shift the destination advances by one, and the
    // next source is the entry just after it.
    assign w_step    = (r_state == S_SHIFT) ? ({1'b0, r_idx} + CNT_W'(1)) : {1'b0, r_idx};
    assign w_src     = w_step + CNT_W'(1);
    assign w_more    = (w_src < r_count);
    assign w_rd_addr = (r_state == S_IDLE) ? w_in_addr : w_src[IDX_W-1:0];

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.data_out   = r_out_data;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.fill_count = r_out_count;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (w_in_cmd == CMD_PUSH || w_in_miss) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_FETCH: begin
                if (r_cmd == CMD_READ || !w_more) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (!w_more) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_cmd        = r_cmd;
        n_idx        = r_idx;
        n_count      = r_count;
        n_res_data   = r_res_data;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        w_we         = 1'b0;
        w_wr_addr    = r_idx;
        w_wr_data    = r_rd_data;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_cmd        = w_in_cmd;
                    n_idx        = w_in_addr;
                    n_res_data   = '0;
                    n_res_status = ST_OK;
                    if (w_in_cmd == CMD_PUSH) begin
                        if (w_full) begin
                            n_res_status = ST_FULL;
                        end else begin
                            w_we      = 1'b1;
                            w_wr_addr = r_count[IDX_W-1:0];
                            w_wr_data = i_req.value;
                            n_count   = r_count + CNT_W'(1);
                        end
                    end else if (w_in_miss) begin
                        n_res_status = ST_MISS;
                    end
                end
            end
            S_FETCH: begin
                n_res_data = r_rd_data;
                if (r_cmd != CMD_READ && !w_more) begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            S_SHIFT: begin
                // The entry read last cycle moves down into the current gap.
                w_we      = 1'b1;
                w_wr_addr = r_idx;
                w_wr_data = r_rd_data;
                n_idx     = w_step[IDX_W-1:0];
                if (!w_more) begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_data   = r_res_data;
                    n_out_status = r_res_status;
                    n_out_count  = r_count;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_idx        <= n_idx;
        r_res_data   <= n_res_data;
        r_res_status <= n_res_status;
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= mem[w_rd_addr];
    end

endmodule

// ===== hw/rtl/idxq_checker.sv =====
module idxq_checker import idxq_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     i_in_ready,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic signed [DATA_W-1:0] i_data_out,
    input logic [1:0]               i_status,
    input logic [CNT_W-1:0]         i_fill_count
);

    // A response is held until the receiver takes it.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("response dropped while stalled");

    // Only one request is in work at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request accepted while another is in work");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_fill_count <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_FULL) |-> i_fill_count == CNT_W'(DEPTH))
        else $error("full status with queue not full");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != ST_OK) |-> i_data_out == '0)
        else $error("nonzero data on failed command");

endmodule

bind indexed_removal_queue_top idxq_checker u_idxq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_data_out   (o_rsp.data_out),
    .i_status     (o_rsp.status),
    .i_fill_count (o_rsp.fill_count)
);
